@@ sv/lsi_pkg.sv @@
// ---------------------------------------------------------------------------
// lsi_pkg: token codes and byte classes for the source lexer
// Token kind codes, character classes, operator pairing and keyword lookup.
// ---------------------------------------------------------------------------
`default_nettype none
package lsi_pkg;

  typedef logic [5:0] tok_kind_t;
  typedef logic [7:0] byte_t;

  localparam tok_kind_t K_IDENT   = 6'd0;
  localparam tok_kind_t K_KEYWORD = 6'd1;
  localparam tok_kind_t K_NUMBER  = 6'd2;
  localparam tok_kind_t K_STRING  = 6'd3;
  localparam tok_kind_t K_CHAR    = 6'd4;
  localparam tok_kind_t K_PLUS    = 6'd5;
  localparam tok_kind_t K_MINUS   = 6'd6;
  localparam tok_kind_t K_STAR    = 6'd7;
  localparam tok_kind_t K_SLASH   = 6'd8;
  localparam tok_kind_t K_PERCENT = 6'd9;
  localparam tok_kind_t K_ASSIGN  = 6'd10;
  localparam tok_kind_t K_PLUSEQ  = 6'd11;
  localparam tok_kind_t K_MINUSEQ = 6'd12;
  localparam tok_kind_t K_STAREQ  = 6'd13;
  localparam tok_kind_t K_SLASHEQ = 6'd14;
  localparam tok_kind_t K_EQEQ    = 6'd15;
  localparam tok_kind_t K_NOTEQ   = 6'd16;
  localparam tok_kind_t K_LT      = 6'd17;
  localparam tok_kind_t K_GT      = 6'd18;
  localparam tok_kind_t K_LE      = 6'd19;
  localparam tok_kind_t K_GE      = 6'd20;
  localparam tok_kind_t K_ANDAND  = 6'd21;
  localparam tok_kind_t K_OROR    = 6'd22;
  localparam tok_kind_t K_BANG    = 6'd23;
  localparam tok_kind_t K_AMP     = 6'd24;
  localparam tok_kind_t K_PIPE    = 6'd25;
  localparam tok_kind_t K_CARET   = 6'd26;
  localparam tok_kind_t K_TILDE   = 6'd27;
  localparam tok_kind_t K_SHL     = 6'd28;
  localparam tok_kind_t K_SHR     = 6'd29;
  localparam tok_kind_t K_DOT     = 6'd30;
  localparam tok_kind_t K_COMMA   = 6'd31;
  localparam tok_kind_t K_COLON   = 6'd32;
  localparam tok_kind_t K_COLCOL  = 6'd33;
  localparam tok_kind_t K_SEMI    = 6'd34;
  localparam tok_kind_t K_ARROW   = 6'd35;
  localparam tok_kind_t K_PIPEGT  = 6'd36;
  localparam tok_kind_t K_RANGE   = 6'd37;
  localparam tok_kind_t K_RANGEEQ = 6'd38;
  localparam tok_kind_t K_QUEST   = 6'd39;
  localparam tok_kind_t K_LPAREN  = 6'd40;
  localparam tok_kind_t K_RPAREN  = 6'd41;
  localparam tok_kind_t K_LBRACE  = 6'd42;
  localparam tok_kind_t K_RBRACE  = 6'd43;
  localparam tok_kind_t K_LBRACK  = 6'd44;
  localparam tok_kind_t K_RBRACK  = 6'd45;
  localparam tok_kind_t K_EOF     = 6'd46;
  localparam tok_kind_t K_UNKNOWN = 6'd47;

  localparam int KW_COUNT = 28;
  localparam logic [63:0] KW_TABLE [KW_COUNT] = '{
    64'("fn"), 64'("let"), 64'("mut"), 64'("const"), 64'("if"), 64'("else"),
    64'("while"), 64'("for"), 64'("in"), 64'("loop"), 64'("break"),
    64'("continue"), 64'("return"), 64'("match"), 64'("type"), 64'("struct"),
    64'("impl"), 64'("enum"), 64'("trait"), 64'("mod"), 64'("use"),
    64'("pub"), 64'("async"), 64'("await"), 64'("spawn"), 64'("macro"),
    64'("true"), 64'("false")
  };

  function automatic logic is_alpha(input byte_t c);
    byte_t l;
    l = c | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input byte_t c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic semi_follows(input tok_kind_t k);
    return (k == K_IDENT) || (k == K_NUMBER) || (k == K_STRING) || (k == K_CHAR) ||
           (k == K_RPAREN) || (k == K_RBRACK) || (k == K_RBRACE) || (k == K_QUEST);
  endfunction

  function automatic logic kw_match(input logic [63:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (KW_TABLE[i] == w) hit = 1'b1;
    end
    return hit;
  endfunction

  // {valid, kind}: operators that may pair with a following byte
  function automatic logic [6:0] op_pend(input byte_t c);
    logic [6:0] r;
    unique case (c)
      "=":     r = {1'b1, K_ASSIGN};
      "!":     r = {1'b1, K_BANG};
      "<":     r = {1'b1, K_LT};
      ">":     r = {1'b1, K_GT};
      "+":     r = {1'b1, K_PLUS};
      "-":     r = {1'b1, K_MINUS};
      "*":     r = {1'b1, K_STAR};
      "/":     r = {1'b1, K_SLASH};
      "&":     r = {1'b1, K_AMP};
      "|":     r = {1'b1, K_PIPE};
      ":":     r = {1'b1, K_COLON};
      ".":     r = {1'b1, K_DOT};
      "#":     r = {1'b1, K_UNKNOWN};
      default: r = {1'b0, K_UNKNOWN};
    endcase
    return r;
  endfunction

  function automatic tok_kind_t op_single(input byte_t c);
    tok_kind_t r;
    unique case (c)
      "%":     r = K_PERCENT;
      "^":     r = K_CARET;
      "~":     r = K_TILDE;
      ",":     r = K_COMMA;
      ";":     r = K_SEMI;
      "?":     r = K_QUEST;
      "(":     r = K_LPAREN;
      ")":     r = K_RPAREN;
      "{":     r = K_LBRACE;
      "}":     r = K_RBRACE;
      "[":     r = K_LBRACK;
      "]":     r = K_RBRACK;
      default: r = K_UNKNOWN;
    endcase
    return r;
  endfunction

  // {valid, kind}: two-byte operator formed by pending kind and next byte
  function automatic logic [6:0] pair_kind(input tok_kind_t k, input byte_t c);
    logic [6:0] r;
    r = {1'b0, K_UNKNOWN};
    unique case (k)
      K_ASSIGN: if (c == "=") r = {1'b1, K_EQEQ};
      K_BANG:   if (c == "=") r = {1'b1, K_NOTEQ};
      K_LT: begin
        if (c == "=") r = {1'b1, K_LE};
        else if (c == "<") r = {1'b1, K_SHL};
      end
      K_GT: begin
        if (c == "=") r = {1'b1, K_GE};
        else if (c == ">") r = {1'b1, K_SHR};
      end
      K_PLUS:  if (c == "=") r = {1'b1, K_PLUSEQ};
      K_MINUS: begin
        if (c == "=") r = {1'b1, K_MINUSEQ};
        else if (c == ">") r = {1'b1, K_ARROW};
      end
      K_STAR:  if (c == "=") r = {1'b1, K_STAREQ};
      K_AMP:   if (c == "&") r = {1'b1, K_ANDAND};
      K_PIPE: begin
        if (c == "|") r = {1'b1, K_OROR};
        else if (c == ">") r = {1'b1, K_PIPEGT};
      end
      K_COLON: if (c == ":") r = {1'b1, K_COLCOL};
      default: r = {1'b0, K_UNKNOWN};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/lsi_if.sv @@
// ---------------------------------------------------------------------------
// lsi_src_if / lsi_tok_if: lexer request channels
// Valid/ready channels for source bytes in and tokens out.
// ---------------------------------------------------------------------------
`default_nettype none
interface lsi_src_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;
  modport source (output valid, kind, ch, input ready);
  modport sink   (input valid, kind, ch, output ready);
endinterface

interface lsi_tok_if #(
  parameter int LINE_WIDTH   = 20,
  parameter int COL_WIDTH    = 16,
  parameter int OFFSET_WIDTH = 24,
  parameter int LENGTH_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [5:0]              token_kind;
  logic [LINE_WIDTH-1:0]   first_line;
  logic [COL_WIDTH-1:0]    first_col;
  logic [OFFSET_WIDTH-1:0] start_offset;
  logic [LENGTH_WIDTH-1:0] span_length;
  logic                    run_last;
  modport source (output valid, token_kind, first_line, first_col, start_offset,
                  span_length, run_last, input ready);
  modport sink   (input valid, token_kind, first_line, first_col, start_offset,
                  span_length, run_last, output ready);
endinterface
`default_nettype wire

@@ sv/source_lexer_with_semicolon_insertion_unit.sv @@
// ---------------------------------------------------------------------------
// source_lexer_with_semicolon_insertion_unit: streaming tokenizer
// Groups source bytes into tokens, inserts semicolons at newlines.
// ---------------------------------------------------------------------------
// Output: a byte's tokens are registered into the token queue.
// Throughput: one request per cycle; each request yields 0..2 tokens, and
//   the output drains one token per cycle while tok is ready, through a
//   4-entry queue, so src stalls only while fewer than two slots are free.
// Reset: rst (synchronous) empties the queue and sets the scanner idle at
//   line 1, column 1, offset 0; an end request resets only the scanner.
`default_nettype none
module source_lexer_with_semicolon_insertion_unit
  import lsi_pkg::*;
#(
  parameter int LINE_WIDTH   = 20,
  parameter int COL_WIDTH    = 16,
  parameter int OFFSET_WIDTH = 24,
  parameter int LENGTH_WIDTH = 16
) (
  input  wire  clk,
  input  wire  rst,
  lsi_src_if.sink  src,
  lsi_tok_if.source tok
);

  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
  localparam logic [COL_WIDTH-1:0]    COL_MAX  = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
  localparam logic [LENGTH_WIDTH-1:0] WORD_MAX = LENGTH_WIDTH'(8);

  // scanner modes
  localparam logic [3:0] M_IDLE = 4'd0, M_WORD = 4'd1, M_NUM = 4'd2, M_NUMDOT = 4'd3,
                         M_STR = 4'd4, M_STRESC = 4'd5, M_CHOPEN = 4'd6, M_CHESC = 4'd7,
                         M_CHBODY = 4'd8, M_OP = 4'd9, M_DOTDOT = 4'd10, M_ATTR = 4'd11,
                         M_LCOM = 4'd12, M_BCOM = 4'd13, M_BSTAR = 4'd14;

  typedef struct packed {
    tok_kind_t               kind;
    logic [LINE_WIDTH-1:0]   line;
    logic [COL_WIDTH-1:0]    col;
    logic [OFFSET_WIDTH-1:0] off;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    last;
  } tok_ent_t;

  // scanner state
  logic [3:0]              mode, mode_next;
  tok_kind_t               pend, pend_next;
  tok_kind_t               prev, prev_next;
  logic [LINE_WIDTH-1:0]   cur_line, cur_line_next;
  logic [COL_WIDTH-1:0]    cur_col, cur_col_next;
  logic [OFFSET_WIDTH-1:0] cur_off, cur_off_next;
  logic [LINE_WIDTH-1:0]   tok_line, tok_line_next;
  logic [COL_WIDTH-1:0]    tok_col, tok_col_next;
  logic [OFFSET_WIDTH-1:0] tok_off, tok_off_next;
  logic [LENGTH_WIDTH-1:0] tok_len, tok_len_next;
  logic [63:0]             wbuf, wbuf_next;
  logic                    too_long, too_long_next;
  // position of a number's '.', kept in case '..' follows
  logic [COL_WIDTH-1:0]    dot_col, dot_col_next;
  logic [OFFSET_WIDTH-1:0] dot_off, dot_off_next;

  // output queue
  tok_ent_t   q_mem [4];
  logic [1:0] q_wr, q_rd;
  logic [2:0] q_cnt;

  logic       acc, pop;
  byte_t      c;
  logic       fv, iv, do_idle;
  tok_kind_t  fk, ik, prev_eff;
  logic [LENGTH_WIDTH-1:0] flen, tl1;
  tok_ent_t   ea, eb;
  logic [6:0] pk, pp;

  assign src.ready = (q_cnt <= 3'd2);
  assign acc       = src.valid & src.ready;
  assign pop       = tok.valid & tok.ready;
  assign c         = src.ch;
  assign tl1       = (tok_len == LEN_MAX) ? tok_len : tok_len + 1'b1;

  always_comb begin
    mode_next = mode; pend_next = pend; prev_next = prev;
    cur_line_next = cur_line; cur_col_next = cur_col; cur_off_next = cur_off;
    tok_line_next = tok_line; tok_col_next = tok_col; tok_off_next = tok_off;
    tok_len_next = tok_len; wbuf_next = wbuf; too_long_next = too_long;
    dot_col_next = dot_col; dot_off_next = dot_off;
    fv = 1'b0; fk = K_UNKNOWN; flen = tok_len;
    iv = 1'b0; ik = K_UNKNOWN; do_idle = 1'b0;
    prev_eff = prev;
    pk = pair_kind(pend, c);
    pp = op_pend(c);
    ea = '0; eb = '0;

    if (src.kind) begin
      // end of source: flush the open token, then Eof
      unique case (mode)
        M_WORD: begin
          fv = 1'b1; fk = (!too_long && kw_match(wbuf)) ? K_KEYWORD : K_IDENT;
        end
        M_NUM:    begin fv = 1'b1; fk = K_NUMBER; end
        M_NUMDOT: begin fv = 1'b1; fk = K_NUMBER; flen = tl1; end
        M_STR, M_STRESC: begin fv = 1'b1; fk = K_STRING; end
        M_CHOPEN, M_CHESC, M_CHBODY: begin fv = 1'b1; fk = K_CHAR; end
        M_OP:     begin fv = 1'b1; fk = pend; end
        M_DOTDOT: begin fv = 1'b1; fk = K_RANGE; end
        M_ATTR:   begin fv = 1'b1; fk = K_KEYWORD; end
        default:  fv = 1'b0;
      endcase
      iv = 1'b1; ik = K_EOF;
      eb = '{kind: K_EOF, line: cur_line, col: cur_col, off: cur_off, len: '0, last: 1'b1};
      mode_next = M_IDLE; pend_next = '0; prev_next = K_UNKNOWN;
      cur_line_next = LINE_WIDTH'(1); cur_col_next = COL_WIDTH'(1); cur_off_next = '0;
      tok_line_next = LINE_WIDTH'(1); tok_col_next = COL_WIDTH'(1); tok_off_next = '0;
      tok_len_next = '0; wbuf_next = '0; too_long_next = 1'b0;
    end else begin
      unique case (mode)
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (tok_len < WORD_MAX) wbuf_next = {wbuf[55:0], c};
            else too_long_next = 1'b1;
            tok_len_next = tl1;
          end else begin
            fv = 1'b1; fk = (!too_long && kw_match(wbuf)) ? K_KEYWORD : K_IDENT;
            do_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) tok_len_next = tl1;
          else if (c == ".") begin
            dot_col_next = cur_col; dot_off_next = cur_off; mode_next = M_NUMDOT;
          end else begin
            fv = 1'b1; fk = K_NUMBER; do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (c == ".") begin
            fv = 1'b1; fk = K_NUMBER;
            tok_col_next = dot_col; tok_off_next = dot_off;
            tok_len_next = LENGTH_WIDTH'(2); mode_next = M_DOTDOT;
          end else if (is_digit(c)) begin
            tok_len_next = (tl1 == LEN_MAX) ? tl1 : tl1 + 1'b1; mode_next = M_NUM;
          end else begin
            fv = 1'b1; fk = K_NUMBER; flen = tl1; do_idle = 1'b1;
          end
        end
        M_STR: begin
          tok_len_next = tl1;
          if (c == "\\") mode_next = M_STRESC;
          else if (c == "\"") begin
            fv = 1'b1; fk = K_STRING; flen = tl1; mode_next = M_IDLE;
          end
        end
        M_STRESC: begin tok_len_next = tl1; mode_next = M_STR; end
        M_CHOPEN: begin
          tok_len_next = tl1; mode_next = (c == "\\") ? M_CHESC : M_CHBODY;
        end
        M_CHESC: begin tok_len_next = tl1; mode_next = M_CHBODY; end
        M_CHBODY: begin
          fv = 1'b1; fk = K_CHAR; flen = tl1; mode_next = M_IDLE;
        end
        M_OP: begin
          priority if (pend == K_SLASH && c == "/") mode_next = M_LCOM;
          else if (pend == K_SLASH && c == "*") mode_next = M_BCOM;
          else if (pend == K_SLASH && c == "=") begin
            fv = 1'b1; fk = K_SLASHEQ; flen = tl1; mode_next = M_IDLE;
          end else if (pend == K_UNKNOWN && c == "[") begin
            tok_len_next = tl1; mode_next = M_ATTR;
          end else if (pend == K_DOT && c == ".") begin
            tok_len_next = tl1; mode_next = M_DOTDOT;
          end else if (pk[6]) begin
            fv = 1'b1; fk = pk[5:0]; flen = tl1; mode_next = M_IDLE;
          end else begin
            fv = 1'b1; fk = pend; do_idle = 1'b1;
          end
        end
        M_DOTDOT: begin
          if (c == "=") begin
            fv = 1'b1; fk = K_RANGEEQ; flen = tl1; mode_next = M_IDLE;
          end else begin
            fv = 1'b1; fk = K_RANGE; do_idle = 1'b1;
          end
        end
        M_ATTR: begin
          tok_len_next = tl1;
          if (c == "]") begin
            fv = 1'b1; fk = K_KEYWORD; flen = tl1; mode_next = M_IDLE;
          end
        end
        M_LCOM: if (c == "\n") do_idle = 1'b1;
        M_BCOM: if (c == "*") mode_next = M_BSTAR;
        M_BSTAR: begin
          if (c == "/") mode_next = M_IDLE;
          else if (c != "*") mode_next = M_BCOM;
        end
        default: do_idle = 1'b1;
      endcase

      // byte seen between tokens
      prev_eff = fv ? fk : prev;
      if (do_idle) begin
        mode_next = M_IDLE;
        priority if (c == "\n") begin
          if (semi_follows(prev_eff)) begin iv = 1'b1; ik = K_SEMI; end
        end else if (is_space(c)) begin
          iv = 1'b0;
        end else if (is_alpha(c) || c == "_" || is_digit(c) || c == "\"" || c == "'" ||
                     pp[6]) begin
          tok_line_next = cur_line; tok_col_next = cur_col; tok_off_next = cur_off;
          tok_len_next = LENGTH_WIDTH'(1);
          priority if (is_alpha(c) || c == "_") begin
            wbuf_next = {56'd0, c}; too_long_next = 1'b0; mode_next = M_WORD;
          end else if (is_digit(c)) mode_next = M_NUM;
          else if (c == "\"") mode_next = M_STR;
          else if (c == "'") mode_next = M_CHOPEN;
          else begin
            pend_next = pp[5:0]; mode_next = M_OP;
          end
        end else begin
          iv = 1'b1; ik = op_single(c);
        end
      end
      eb = '{kind: ik, line: cur_line, col: cur_col, off: cur_off,
             len: LENGTH_WIDTH'(1), last: 1'b1};

      cur_line_next = (c == "\n") ? ((cur_line == LINE_MAX) ? cur_line : cur_line + 1'b1)
                                  : cur_line;
      cur_col_next  = (c == "\n") ? COL_WIDTH'(1)
                                  : ((cur_col == COL_MAX) ? cur_col : cur_col + 1'b1);
      cur_off_next  = cur_off + 1'b1;
      if (iv) prev_next = ik;
      else if (fv) prev_next = fk;
    end

    ea = '{kind: fk, line: tok_line, col: tok_col, off: tok_off, len: flen, last: !iv};
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= '0; prev <= K_UNKNOWN;
      cur_line <= LINE_WIDTH'(1); cur_col <= COL_WIDTH'(1); cur_off <= '0;
      tok_line <= LINE_WIDTH'(1); tok_col <= COL_WIDTH'(1); tok_off <= '0;
      tok_len <= '0; wbuf <= '0; too_long <= 1'b0;
    end else if (acc) begin
      mode <= mode_next; pend <= pend_next; prev <= prev_next;
      cur_line <= cur_line_next; cur_col <= cur_col_next; cur_off <= cur_off_next;
      tok_line <= tok_line_next; tok_col <= tok_col_next; tok_off <= tok_off_next;
      tok_len <= tok_len_next; wbuf <= wbuf_next; too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dot_col <= dot_col_next; dot_off <= dot_off_next;
    end
  end

  // token queue: up to two writes, one read per cycle
  logic [1:0] n_wr;
  assign n_wr = acc ? (2'(fv) + 2'(iv)) : 2'd0;

  always_ff @(posedge clk) begin
    if (acc) begin
      if (fv) begin
        q_mem[q_wr] <= ea;
        if (iv) q_mem[q_wr + 2'd1] <= eb;
      end else if (iv) begin
        q_mem[q_wr] <= eb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr <= '0; q_rd <= '0; q_cnt <= '0;
    end else begin
      q_wr  <= q_wr + n_wr;
      q_rd  <= q_rd + 2'(pop);
      q_cnt <= q_cnt + 3'(n_wr) - 3'(pop);
    end
  end

  assign tok.valid        = (q_cnt != 3'd0);
  assign tok.token_kind   = q_mem[q_rd].kind;
  assign tok.first_line   = q_mem[q_rd].line;
  assign tok.first_col    = q_mem[q_rd].col;
  assign tok.start_offset = q_mem[q_rd].off;
  assign tok.span_length  = q_mem[q_rd].len;
  assign tok.run_last     = q_mem[q_rd].last;

  // checks
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 3'd4)
    else $error("token queue over capacity");
  a_room: assert property (@(posedge clk) disable iff (rst) acc |-> q_cnt <= 3'd2)
    else $error("request taken without room for two tokens");
  a_word_len: assert property (@(posedge clk) disable iff (rst)
    mode == M_WORD |-> tok_len != '0)
    else $error("word open with zero length");
  a_prev_eof: assert property (@(posedge clk) disable iff (rst) prev != K_EOF)
    else $error("Eof left as previous token");
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    acc && src.kind |=> mode == M_IDLE && cur_off == '0)
    else $error("end request did not restart scanner");

endmodule
`default_nettype wire
